FILE: rtl/sector_buffer_cache_lru_unit_macros.svh
// Assertion macros shared by the checker of the sector buffer cache.
// Each macro expands to one labeled concurrent assertion on clock and reset.
`ifndef SECTOR_BUFFER_CACHE_LRU_UNIT_MACROS_SVH
`define SECTOR_BUFFER_CACHE_LRU_UNIT_MACROS_SVH

// Same-cycle implication.
`define SBC_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sbc assertion failed");

// Next-cycle implication.
`define SBC_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sbc assertion failed");

`endif

FILE: rtl/sbc_pkg.sv
// Shared types and constants of the sector buffer cache.
// Used by the controller, the top level and the checker.
package sbc_pkg;

   localparam int ENTRIES_DEF = 128;

   // Request kinds.
   localparam logic [2:0] KIND_GET     = 3'd0;
   localparam logic [2:0] KIND_LOAD    = 3'd1;
   localparam logic [2:0] KIND_SYNC    = 3'd2;
   localparam logic [2:0] KIND_RELEASE = 3'd3;
   localparam logic [2:0] KIND_MARK    = 3'd4;

   // Result status codes.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_BUSY  = 2'd1;
   localparam logic [1:0] STAT_UNDER = 2'd2;
   localparam logic [1:0] STAT_OVER  = 2'd3;

   // Transfer codes.
   localparam logic [1:0] IO_NONE  = 2'd0;
   localparam logic [1:0] IO_WRITE = 2'd1;
   localparam logic [1:0] IO_READ  = 2'd2;

   // One entry's record in the info memory.
   typedef struct packed {
      logic        valid;
      logic [15:0] device;
      logic [31:0] sector;
      logic [7:0]  count;
      logic        dirty;
      logic        fresh;
   } info_type;

   localparam int INFO_W = 59;

   // One result item.
   typedef struct packed {
      logic [1:0]  status;
      logic [6:0]  entry;
      logic        hit;
      logic [1:0]  io_op;
      logic [15:0] io_device;
      logic [31:0] io_sector;
      logic        last;
   } rsp_type;

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE, S_SCAN, S_MISS_RD, S_MISS_CK, S_HIT, S_SLOT_RD, S_SLOT_CK,
      S_MV_RD, S_UN1, S_UN2, S_TI1, S_TI2, S_WK_ST, S_WK, S_IB1, S_IB2, S_IB3, S_OUT
   } state_type;

endpackage

FILE: rtl/sector_buffer_cache_lru_unit.sv
// Sector buffer cache with reference counts and an LRU list.
// Get: tag scan, one info memory read per cycle.
// Release to zero: list walk, one link read per cycle.
// One request at a time; a result waits in an output register while the next request
// is taken. After reset a clearing pass over all ENTRIES entries runs before the first
// request is accepted.
module sector_buffer_cache_lru_unit #(
   parameter int ENTRIES = sbc_pkg::ENTRIES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // device[15:0], sector[47:16], slot[54:48], zero
   input  logic [2:0]  req_tuser,   // kind[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // status[1:0], entry[8:2], hit[9], io_op[11:10],
                                    // io_device[27:12], io_sector[59:28], zero
   output logic        rsp_tlast    // last
);

   logic             res_valid, res_ready;
   sbc_pkg::rsp_type res;
   sbc_pkg::rsp_type out_ff, out_in;
   logic             out_v_ff, out_v_in;

   sbc_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_kind   (req_tuser),
      .req_device (req_tdata[15:0]),
      .req_sector (req_tdata[47:16]),
      .req_slot   (req_tdata[54:48]),
      .res_valid  (res_valid),
      .res_ready  (res_ready),
      .res        (res)
   );

   // Output register: refilled when empty or being drained.
   assign res_ready = !out_v_ff || rsp_tready;

   always_comb begin
      out_in   = out_ff;
      out_v_in = out_v_ff;
      if (res_valid && res_ready) begin
         out_in   = res;
         out_v_in = 1'b1;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {4'd0, out_ff.io_sector, out_ff.io_device, out_ff.io_op,
                        out_ff.hit, out_ff.entry, out_ff.status};
   assign rsp_tlast  = out_ff.last;

endmodule

FILE: rtl/sbc_ram.sv
// Single-write, single-read synchronous memory with lane write enables.
// Read data is registered. No package dependency.
module sbc_ram #(
   parameter int LW    = 8,
   parameter int LANES = 1,
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic                  clock,
   input  logic [LANES-1:0]      we,
   input  logic [AW-1:0]         waddr,
   input  logic [LANES*LW-1:0]   wdata,
   input  logic [AW-1:0]         raddr,
   output logic [LANES*LW-1:0]   rdata
);

   logic [LANES*LW-1:0] mem_ff [DEPTH];
   logic [LANES*LW-1:0] rdata_ff;

   // Lane-masked write port.
   always_ff @(posedge clock) begin
      for (int l = 0; l < LANES; l++) begin
         if (we[l]) begin
            mem_ff[waddr][l*LW +: LW] <= wdata[l*LW +: LW];
         end
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: rtl/sbc_ctrl.sv
// Request sequencer of the sector buffer cache: tag scan, count updates and
// LRU list edits over the info and link memories. Depends on sbc_pkg, sbc_ram.
module sbc_ctrl #(
   parameter int ENTRIES = sbc_pkg::ENTRIES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_kind,
   input  logic [15:0]         req_device,
   input  logic [31:0]         req_sector,
   input  logic [6:0]          req_slot,
   output logic                res_valid,
   input  logic                res_ready,
   output sbc_pkg::rsp_type    res
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

   sbc_pkg::state_type state_ff, state_in;
   logic [2:0]  kind_ff, kind_in;
   logic [15:0] dev_ff, dev_in;
   logic [31:0] sec_ff, sec_in;
   logic [6:0]  slot_ff, slot_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic [IW-1:0] chk_ff, chk_in;
   logic          chk_v_ff, chk_v_in;
   sbc_pkg::info_type cur_ff, cur_in;
   logic [IW-1:0] tgt_ff, tgt_in, lp_ff, lp_in, ln_ff, ln_in;
   logic [IW-1:0] w_ff, w_in, u_ff, u_in, up_ff, up_in;
   logic [IW-1:0] head_ff, head_in, tail_ff, tail_in, clr_ff, clr_in;
   logic          rel_ff, rel_in, second_ff, second_in;
   sbc_pkg::rsp_type res_ff, res_in;

   // Memory ports.
   logic                    info_we;
   logic [IW-1:0]           info_waddr, info_raddr;
   sbc_pkg::info_type       info_wdata, info_rd;
   logic [sbc_pkg::INFO_W-1:0] info_rdata;
   logic [1:0]              link_we;
   logic [IW-1:0]           link_waddr, link_raddr;
   logic [2*IW-1:0]         link_wdata, link_rdata;
   logic [IW-1:0]           link_next, link_prev;
   logic [IW-1:0]           slot_idx;
   sbc_pkg::info_type       wrec;

   sbc_ram #(.LW(sbc_pkg::INFO_W), .LANES(1), .DEPTH(ENTRIES), .AW(IW)) u_info (
      .clock (clock),
      .we    (info_we),
      .waddr (info_waddr),
      .wdata (info_wdata),
      .raddr (info_raddr),
      .rdata (info_rdata)
   );

   // Link lanes: lane 0 is next, lane 1 is prev.
   sbc_ram #(.LW(IW), .LANES(2), .DEPTH(ENTRIES), .AW(IW)) u_link (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   assign info_rd   = sbc_pkg::info_type'(info_rdata);
   assign link_next = link_rdata[IW-1:0];
   assign link_prev = link_rdata[2*IW-1:IW];
   assign slot_idx  = IW'(slot_ff);
   assign res       = res_ff;

   // State and datapath registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sbc_pkg::S_CLEAR;
         clr_ff    <= '0;
         second_ff <= 1'b0;
         chk_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         second_ff <= second_in;
         chk_v_ff  <= chk_v_in;
      end
      kind_ff <= kind_in;
      dev_ff  <= dev_in;
      sec_ff  <= sec_in;
      slot_ff <= slot_in;
      scan_ff <= scan_in;
      chk_ff  <= chk_in;
      cur_ff  <= cur_in;
      tgt_ff  <= tgt_in;
      lp_ff   <= lp_in;
      ln_ff   <= ln_in;
      w_ff    <= w_in;
      u_ff    <= u_in;
      up_ff   <= up_in;
      head_ff <= head_in;
      tail_ff <= tail_in;
      rel_ff  <= rel_in;
      res_ff  <= res_in;
   end

   // Next state, memory commands and results.
   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      dev_in    = dev_ff;
      sec_in    = sec_ff;
      slot_in   = slot_ff;
      scan_in   = scan_ff;
      chk_in    = chk_ff;
      chk_v_in  = chk_v_ff;
      cur_in    = cur_ff;
      tgt_in    = tgt_ff;
      lp_in     = lp_ff;
      ln_in     = ln_ff;
      w_in      = w_ff;
      u_in      = u_ff;
      up_in     = up_ff;
      head_in   = head_ff;
      tail_in   = tail_ff;
      clr_in    = clr_ff;
      rel_in    = rel_ff;
      second_in = second_ff;
      res_in    = res_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      info_we    = 1'b0;
      info_waddr = tgt_ff;
      info_wdata = '0;
      info_raddr = tgt_ff;
      link_we    = 2'b00;
      link_waddr = tgt_ff;
      link_wdata = '0;
      link_raddr = tgt_ff;
      wrec       = info_rd;

      case (state_ff)
         // Clearing pass: zero records, chain entries in index order.
         sbc_pkg::S_CLEAR: begin
            info_we    = 1'b1;
            info_waddr = clr_ff;
            link_we    = 2'b11;
            link_waddr = clr_ff;
            link_wdata = {clr_ff - IW'(1), clr_ff + IW'(1)};
            clr_in     = clr_ff + IW'(1);
            if (clr_ff == LAST_IDX) begin
               head_in  = '0;
               tail_in  = LAST_IDX;
               state_in = sbc_pkg::S_IDLE;
            end
         end

         sbc_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in = req_kind;
               dev_in  = req_device;
               sec_in  = req_sector;
               slot_in = req_slot;
               second_in     = 1'b0;
               res_in        = '0;
               res_in.entry  = req_slot;
               res_in.last   = 1'b1;
               res_in.status = sbc_pkg::STAT_OK;
               res_in.io_op  = sbc_pkg::IO_NONE;
               if (req_kind == sbc_pkg::KIND_GET) begin
                  scan_in  = '0;
                  chk_v_in = 1'b0;
                  state_in = sbc_pkg::S_SCAN;
               end else if (req_kind > sbc_pkg::KIND_MARK || 32'(req_slot) >= ENTRIES) begin
                  state_in = sbc_pkg::S_OUT;
               end else begin
                  state_in = sbc_pkg::S_SLOT_RD;
               end
            end
         end

         // Tag scan, one entry per cycle, lowest match wins.
         sbc_pkg::S_SCAN: begin
            info_raddr = scan_ff[IW-1:0];
            if (chk_v_ff && info_rd.valid && info_rd.device == dev_ff &&
                info_rd.sector == sec_ff) begin
               cur_in   = info_rd;
               tgt_in   = chk_ff;
               state_in = sbc_pkg::S_HIT;
            end else if (chk_v_ff && chk_ff == LAST_IDX) begin
               state_in = sbc_pkg::S_MISS_RD;
            end else begin
               chk_in   = scan_ff[IW-1:0];
               chk_v_in = 1'b1;
               scan_in  = scan_ff + CW'(1);
            end
         end

         sbc_pkg::S_MISS_RD: begin
            info_raddr = head_ff;
            state_in   = sbc_pkg::S_MISS_CK;
         end

         // Claim the LRU head unless it is in use.
         sbc_pkg::S_MISS_CK: begin
            res_in.entry = 7'(head_ff);
            res_in.hit   = 1'b0;
            if (info_rd.count != 8'd0) begin
               res_in.status = sbc_pkg::STAT_BUSY;
               state_in      = sbc_pkg::S_OUT;
            end else begin
               info_we    = 1'b1;
               info_waddr = head_ff;
               info_wdata = '{valid: 1'b1, device: dev_ff, sector: sec_ff,
                              count: 8'd1, dirty: 1'b0, fresh: 1'b0};
               tgt_in     = head_ff;
               rel_in     = 1'b0;
               state_in   = sbc_pkg::S_MV_RD;
            end
         end

         sbc_pkg::S_HIT: begin
            res_in.entry = 7'(tgt_ff);
            res_in.hit   = 1'b1;
            if (cur_ff.count == 8'hFF) begin
               res_in.status = sbc_pkg::STAT_OVER;
               state_in      = sbc_pkg::S_OUT;
            end else begin
               info_we          = 1'b1;
               info_wdata       = cur_ff;
               info_wdata.count = cur_ff.count + 8'd1;
               rel_in           = 1'b0;
               state_in         = sbc_pkg::S_MV_RD;
            end
         end

         sbc_pkg::S_SLOT_RD: begin
            info_raddr = slot_idx;
            state_in   = sbc_pkg::S_SLOT_CK;
         end

         // Read-modify-write of the slot's record.
         sbc_pkg::S_SLOT_CK: begin
            tgt_in     = slot_idx;
            info_waddr = slot_idx;
            info_wdata = wrec;
            state_in   = sbc_pkg::S_OUT;
            case (kind_ff)
               sbc_pkg::KIND_LOAD: begin
                  if (!info_rd.fresh) begin
                     wrec.fresh = 1'b1;
                     wrec.dirty = 1'b0;
                     info_wdata = wrec;
                     info_we    = 1'b1;
                     res_in.io_op     = info_rd.dirty ? sbc_pkg::IO_WRITE : sbc_pkg::IO_READ;
                     res_in.io_device = info_rd.device;
                     res_in.io_sector = info_rd.sector;
                     res_in.last      = !info_rd.dirty;
                     second_in        = info_rd.dirty;
                  end
               end
               sbc_pkg::KIND_SYNC: begin
                  if (info_rd.fresh && info_rd.dirty) begin
                     wrec.dirty = 1'b0;
                     info_wdata = wrec;
                     info_we    = 1'b1;
                     res_in.io_op     = sbc_pkg::IO_WRITE;
                     res_in.io_device = info_rd.device;
                     res_in.io_sector = info_rd.sector;
                  end
               end
               sbc_pkg::KIND_RELEASE: begin
                  if (info_rd.count == 8'd0) begin
                     res_in.status = sbc_pkg::STAT_UNDER;
                  end else begin
                     wrec.count = info_rd.count - 8'd1;
                     if (info_rd.count == 8'd1) begin
                        if (info_rd.fresh && info_rd.dirty) begin
                           wrec.dirty       = 1'b0;
                           res_in.io_op     = sbc_pkg::IO_WRITE;
                           res_in.io_device = info_rd.device;
                           res_in.io_sector = info_rd.sector;
                        end
                        rel_in   = 1'b1;
                        state_in = sbc_pkg::S_MV_RD;
                     end
                     info_wdata = wrec;
                     info_we    = 1'b1;
                  end
               end
               sbc_pkg::KIND_MARK: begin
                  wrec.dirty = 1'b1;
                  info_wdata = wrec;
                  info_we    = 1'b1;
               end
               default: begin
                  info_we = 1'b0;
               end
            endcase
         end

         sbc_pkg::S_MV_RD: begin
            link_raddr = tgt_ff;
            state_in   = sbc_pkg::S_UN1;
         end

         // Unlink, first half: predecessor's next pointer or the head.
         sbc_pkg::S_UN1: begin
            lp_in = link_prev;
            ln_in = link_next;
            if (!rel_ff && tgt_ff == tail_ff) begin
               state_in = sbc_pkg::S_OUT;
            end else begin
               if (tgt_ff == head_ff) begin
                  head_in = link_next;
               end else begin
                  link_we    = 2'b01;
                  link_waddr = link_prev;
                  link_wdata = {IW'(0), link_next};
               end
               state_in = sbc_pkg::S_UN2;
            end
         end

         // Unlink, second half: successor's prev pointer or the tail.
         sbc_pkg::S_UN2: begin
            if (tgt_ff == tail_ff) begin
               tail_in = lp_ff;
            end else begin
               link_we    = 2'b10;
               link_waddr = ln_ff;
               link_wdata = {lp_ff, IW'(0)};
            end
            state_in = rel_ff ? sbc_pkg::S_WK_ST : sbc_pkg::S_TI1;
         end

         // Append at the tail.
         sbc_pkg::S_TI1: begin
            link_we    = 2'b01;
            link_waddr = tail_ff;
            link_wdata = {IW'(0), tgt_ff};
            state_in   = sbc_pkg::S_TI2;
         end

         sbc_pkg::S_TI2: begin
            link_we    = 2'b10;
            link_waddr = tgt_ff;
            link_wdata = {tail_ff, IW'(0)};
            tail_in    = tgt_ff;
            state_in   = sbc_pkg::S_OUT;
         end

         // Walk from the head for the first entry in use.
         sbc_pkg::S_WK_ST: begin
            link_raddr = head_ff;
            info_raddr = head_ff;
            w_in       = head_ff;
            state_in   = sbc_pkg::S_WK;
         end

         sbc_pkg::S_WK: begin
            if (info_rd.count != 8'd0) begin
               u_in     = w_ff;
               up_in    = link_prev;
               state_in = sbc_pkg::S_IB1;
            end else if (w_ff == tail_ff) begin
               state_in = sbc_pkg::S_TI1;
            end else begin
               w_in       = link_next;
               link_raddr = link_next;
               info_raddr = link_next;
            end
         end

         // Insert ahead of the entry found.
         sbc_pkg::S_IB1: begin
            link_we    = 2'b11;
            link_waddr = tgt_ff;
            link_wdata = {up_ff, u_ff};
            state_in   = sbc_pkg::S_IB2;
         end

         sbc_pkg::S_IB2: begin
            if (u_ff == head_ff) begin
               head_in = tgt_ff;
            end else begin
               link_we    = 2'b01;
               link_waddr = up_ff;
               link_wdata = {IW'(0), tgt_ff};
            end
            state_in = sbc_pkg::S_IB3;
         end

         sbc_pkg::S_IB3: begin
            link_we    = 2'b10;
            link_waddr = u_ff;
            link_wdata = {tgt_ff, IW'(0)};
            state_in   = sbc_pkg::S_OUT;
         end

         // Hand results to the output register.
         sbc_pkg::S_OUT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               if (second_ff) begin
                  res_in.io_op = sbc_pkg::IO_READ;
                  res_in.last  = 1'b1;
                  second_in    = 1'b0;
               end else begin
                  state_in = sbc_pkg::S_IDLE;
               end
            end
         end

         default: begin
            state_in = sbc_pkg::S_IDLE;
         end
      endcase
   end

endmodule

FILE: rtl/sbc_checker.sv
// Port-level checker of the sector buffer cache, bound to the top level.
// Depends on sbc_pkg and the assertion macros header.
`include "sector_buffer_cache_lru_unit_macros.svh"

module sbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic        rsp_tlast
);

   // A stalled result holds.
   `SBC_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // The block works on one request at a time.
   `SBC_ASSERT_NEXT(a_one_at_a_time, req_tvalid && req_tready, !req_tready)

   // Only a write-back precedes another result of the same request.
   `SBC_ASSERT_NOW(a_first_is_write, rsp_tvalid && !rsp_tlast, rsp_tdata[11:10] == sbc_pkg::IO_WRITE)

   // No transfer means no device or sector.
   `SBC_ASSERT_NOW(a_no_io_zero, rsp_tvalid && rsp_tdata[11:10] == sbc_pkg::IO_NONE, rsp_tdata[59:12] == 48'd0)

endmodule

bind sector_buffer_cache_lru_unit sbc_checker u_sbc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
